FILE: src/pjpa_pkg.sv
// Package for the jackknife pair accumulator: shared constants, register
// indexes and the command/status structs between controller and datapath.
// No dependencies.
package pjpa_pkg;

   localparam int MAX_REGIONS_DEF = 254;
   localparam int MASK_BITS_DEF   = 31;
   localparam int MASK_WORDS_DEF  = 60;

   localparam int BIN_W     = 63;
   localparam int CNT_W     = 11;
   localparam int WEIGHT_W  = 16;
   localparam int REGION_W  = 9;
   localparam int BIN_IDX_W = 8;
   localparam int NR_W      = 8;
   localparam int JK_W      = 16;

   localparam logic [CNT_W-1:0] OVERLAP_MAX = '1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_REGIONS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JK_WEIGHT   = 2'd1;

   localparam logic [NR_W-1:0] NUM_REGIONS_RST = 8'd100;
   localparam logic [JK_W-1:0] JK_WEIGHT_RST   = 16'd19386;

   typedef struct packed {
      logic accept;
      logic scale;
      logic div_step;
      logic jk_lo;
      logic jk_hi;
      logic walk_issue;
      logic clr_wr;
      logic k_clear;
      logic k_inc;
   } pjpa_cmd_type;

   typedef struct packed {
      logic pair_go;
      logic div_last;
      logic k_clr_end;
      logic k_walk_end;
   } pjpa_stat_type;

endpackage

FILE: src/pip_jackknife_pair_accumulator.sv
// Top level of the PIP-weighted jackknife pair accumulator.
// Depends on pjpa_pkg, pjpa_ctrl, pjpa_dp (which holds pjpa_ram).
//
//  channel   ports                 transfer when
//  request   start/busy, req_*     start high and busy low
//  response  rsp_valid, rsp_*      rsp_valid high (one cycle, no stall)
//  config    csr_valid/csr_ready   csr_valid and csr_ready high
//
// After reset the bin store is cleared, one bin a cycle, all MAX_REGIONS+2
// bins with busy high. A mask word that does not start a pair leaves busy
// low. The last word of a selected pair with non-zero overlap keeps busy high
// through scaling, serial divide (one quotient bit a cycle), jackknife
// scaling, one read-modify-write of the bin store per bin for R+2 bins (R the
// clipped region count) and a drain state. A read item's result shows on the next cycle.
// The receiver cannot stall; configuration writes are always taken.
module pip_jackknife_pair_accumulator
   import pjpa_pkg::*;
#(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF,
   parameter int MASK_BITS   = MASK_BITS_DEF,
   parameter int MASK_WORDS  = MASK_WORDS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_func,
   input  logic [MASK_BITS-1:0]       req_mask_a,
   input  logic [MASK_BITS-1:0]       req_mask_b,
   input  logic                       req_last_word,
   input  logic                       req_selected_a,
   input  logic                       req_selected_b,
   input  logic [WEIGHT_W-1:0]        req_weight_a,
   input  logic [WEIGHT_W-1:0]        req_weight_b,
   input  logic signed [REGION_W-1:0] req_region_a,
   input  logic signed [REGION_W-1:0] req_region_b,
   input  logic [BIN_IDX_W-1:0]       req_bin_index,
   // response channel
   output logic                       rsp_valid,
   output logic [BIN_W-1:0]           rsp_bin_value,
   output logic                       rsp_zero_overlap_seen,
   // configuration channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   pjpa_cmd_type  cmd;
   pjpa_stat_type st;

   // registers are plain flops, a write can always land
   assign csr_ready = 1'b1;

   pjpa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   pjpa_dp #(
      .MAX_REGIONS (MAX_REGIONS),
      .MASK_BITS   (MASK_BITS),
      .MASK_WORDS  (MASK_WORDS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .st                    (st),
      .req_func              (req_func),
      .req_mask_a            (req_mask_a),
      .req_mask_b            (req_mask_b),
      .req_last_word         (req_last_word),
      .req_selected_a        (req_selected_a),
      .req_selected_b        (req_selected_b),
      .req_weight_a          (req_weight_a),
      .req_weight_b          (req_weight_b),
      .req_region_a          (req_region_a),
      .req_region_b          (req_region_b),
      .req_bin_index         (req_bin_index),
      .csr_wr                (csr_valid && csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_valid             (rsp_valid),
      .rsp_bin_value         (rsp_bin_value),
      .rsp_zero_overlap_seen (rsp_zero_overlap_seen)
   );

endmodule

FILE: src/pjpa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pjpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: src/pjpa_ctrl.sv
// Controller of the pair accumulator: sequences clear pass, scaling, divide,
// jackknife scaling and bin walk. Depends on pjpa_pkg.
module pjpa_ctrl
   import pjpa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  pjpa_stat_type st,
   output pjpa_cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_SCALE = 8'b0000_0100,
      S_DIV   = 8'b0000_1000,
      S_JKLO  = 8'b0001_0000,
      S_JKHI  = 8'b0010_0000,
      S_WALK  = 8'b0100_0000,
      S_DRAIN = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            cmd.k_inc  = 1'b1;
            if (st.k_clr_end) begin
               cmd.k_clear = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.accept = start;
            if (start && st.pair_go) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               state_in = S_JKLO;
            end
         end
         S_JKLO: begin
            cmd.jk_lo = 1'b1;
            state_in  = S_JKHI;
         end
         S_JKHI: begin
            cmd.jk_hi   = 1'b1;
            cmd.k_clear = 1'b1;
            state_in    = S_WALK;
         end
         S_WALK: begin
            cmd.walk_issue = 1'b1;
            cmd.k_inc      = 1'b1;
            if (st.k_walk_end) begin
               cmd.k_clear = 1'b1;
               state_in    = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

FILE: src/pjpa_dp.sv
// Datapath of the pair accumulator: overlap count, weight multiply, serial
// divider, jackknife scaling, bin store access. Depends on pjpa_pkg, pjpa_ram.
module pjpa_dp
   import pjpa_pkg::*;
#(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF,
   parameter int MASK_BITS   = MASK_BITS_DEF,
   parameter int MASK_WORDS  = MASK_WORDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pjpa_cmd_type                cmd,
   output pjpa_stat_type               st,
   input  logic                        req_func,
   input  logic [MASK_BITS-1:0]        req_mask_a,
   input  logic [MASK_BITS-1:0]        req_mask_b,
   input  logic                        req_last_word,
   input  logic                        req_selected_a,
   input  logic                        req_selected_b,
   input  logic [WEIGHT_W-1:0]         req_weight_a,
   input  logic [WEIGHT_W-1:0]         req_weight_b,
   input  logic signed [REGION_W-1:0]  req_region_a,
   input  logic signed [REGION_W-1:0]  req_region_b,
   input  logic [BIN_IDX_W-1:0]        req_bin_index,
   input  logic                        csr_wr,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data,
   output logic                        rsp_valid,
   output logic [BIN_W-1:0]            rsp_bin_value,
   output logic                        rsp_zero_overlap_seen
);

   localparam int NUM_BINS = MAX_REGIONS + 2;
   localparam int KW       = $clog2(NUM_BINS);
   localparam int COV      = MASK_BITS * MASK_WORDS;
   localparam int COV_W    = $clog2(COV + 1);
   localparam int WAB_W    = 2 * WEIGHT_W;
   localparam int PROD_W   = WAB_W + COV_W;
   localparam int SW       = $clog2(PROD_W + 1);
   localparam int HALF     = (PROD_W + 1) / 2;
   localparam int SUM_W    = PROD_W + JK_W;
   localparam int POP_W    = $clog2(MASK_BITS + 1);
   localparam int NRW_W    = KW + NR_W;
   localparam int CMP_W    = ((KW > REGION_W) ? KW : REGION_W) + 2;

   // configuration
   logic [NR_W-1:0] num_regions_ff;
   logic [JK_W-1:0] jk_weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_regions_ff <= NUM_REGIONS_RST;
         jk_weight_ff   <= JK_WEIGHT_RST;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_NUM_REGIONS: num_regions_ff <= csr_data[NR_W-1:0];
            CSR_JK_WEIGHT:   jk_weight_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // overlap count
   logic [CNT_W-1:0] cnt_ff;
   logic             zflag_ff;
   logic [POP_W-1:0] pop;
   logic [CNT_W:0]   csum;
   logic [CNT_W-1:0] cnt_new;
   logic [MASK_BITS-1:0] both_bits;

   always_comb begin
      both_bits = req_mask_a & req_mask_b;
      pop = '0;
      for (int i = 0; i < MASK_BITS; i++) begin
         pop = pop + POP_W'(both_bits[i]);
      end
      csum    = {1'b0, cnt_ff} + (CNT_W + 1)'(pop);
      cnt_new = csum[CNT_W] ? OVERLAP_MAX : csum[CNT_W-1:0];
   end

   logic mask_acc, sel_both;
   assign mask_acc   = cmd.accept && !req_func;
   assign sel_both   = req_selected_a && req_selected_b;
   assign st.pair_go = !req_func && req_last_word && sel_both && (cnt_new != '0);

   // pair operands
   logic [WAB_W-1:0]           wab_ff;
   logic [CNT_W-1:0]           div_ff;
   logic signed [REGION_W-1:0] ra_ff, rb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         zflag_ff <= 1'b0;
      end else if (mask_acc) begin
         if (req_last_word) begin
            cnt_ff <= '0;
            if (sel_both && cnt_new == '0) begin
               zflag_ff <= 1'b1;
            end
         end else begin
            cnt_ff <= cnt_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mask_acc && st.pair_go) begin
         wab_ff <= WAB_W'(req_weight_a) * WAB_W'(req_weight_b);
         div_ff <= cnt_new;
         ra_ff  <= req_region_a;
         rb_ff  <= req_region_b;
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [PROD_W-1:0] quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [SW-1:0]     step_ff;
   logic [CNT_W:0]    rem_sh;
   logic              ge;

   assign rem_sh      = {rem_ff, quo_ff[PROD_W-1]};
   assign ge          = (rem_sh >= {1'b0, div_ff});
   assign st.div_last = (step_ff == SW'(PROD_W - 1));

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         quo_ff  <= PROD_W'(wab_ff) * PROD_W'(COV);
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? CNT_W'(rem_sh - {1'b0, div_ff}) : rem_sh[CNT_W-1:0];
         quo_ff  <= {quo_ff[PROD_W-2:0], ge};
         step_ff <= step_ff + 1'b1;
      end
   end

   // jackknife weight in two partial products
   logic [HALF+JK_W-1:0] pl_ff;
   logic [PROD_W-1:0]    wj_ff;
   logic [SUM_W-1:0]     jsum;

   assign jsum = ((SUM_W'(quo_ff[PROD_W-1:HALF]) * SUM_W'(jk_weight_ff)) << HALF)
               + SUM_W'(pl_ff);

   always_ff @(posedge clock) begin
      if (cmd.jk_lo) begin
         pl_ff <= (HALF + JK_W)'(quo_ff[HALF-1:0]) * (HALF + JK_W)'(jk_weight_ff);
      end
      if (cmd.jk_hi) begin
         wj_ff <= jsum[SUM_W-1:JK_W];
      end
   end

   // bin walk
   logic [KW-1:0]    k_ff;
   logic [KW-1:0]    end_k;
   logic [NRW_W-1:0] nr_wide;

   always_comb begin
      nr_wide = NRW_W'(num_regions_ff);
      if (nr_wide > NRW_W'(MAX_REGIONS)) begin
         nr_wide = NRW_W'(MAX_REGIONS);
      end
      end_k = KW'(nr_wide + 1'b1);
   end

   assign st.k_walk_end = (k_ff == end_k);
   assign st.k_clr_end  = (k_ff == KW'(NUM_BINS - 1));

   always_ff @(posedge clock) begin
      if (reset || cmd.k_clear) begin
         k_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   logic signed [CMP_W-1:0] kc, rac, rbc;
   logic both_assigned, ma, mb, add_w, add_j;
   logic [PROD_W-1:0] amount;

   always_comb begin
      kc            = CMP_W'(k_ff);
      rac           = CMP_W'(ra_ff);
      rbc           = CMP_W'(rb_ff);
      both_assigned = (ra_ff != -9'sd1) && (rb_ff != -9'sd1);
      ma            = (rac == kc);
      mb            = (rbc == kc);
      add_w         = st.k_walk_end || (both_assigned && !ma && !mb);
      add_j         = both_assigned && !(ma && mb);
      if (add_w) begin
         amount = quo_ff;
      end else if (add_j) begin
         amount = wj_ff;
      end else begin
         amount = '0;
      end
   end

   logic              wr_pend_ff;
   logic [KW-1:0]     wk_ff;
   logic [PROD_W-1:0] amt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.walk_issue;
      end
      wk_ff  <= k_ff;
      amt_ff <= amount;
   end

   // bin store
   logic [BIN_W-1:0] ram_rdata, ram_wdata;
   logic [KW-1:0]    ram_raddr, ram_waddr;
   logic             ram_we;
   logic [BIN_W:0]   bsum;

   assign bsum      = {1'b0, ram_rdata} + (BIN_W + 1)'(amt_ff);
   assign ram_we    = cmd.clr_wr || wr_pend_ff;
   assign ram_waddr = cmd.clr_wr ? k_ff : wk_ff;
   assign ram_wdata = cmd.clr_wr ? '0 : (bsum[BIN_W] ? '1 : bsum[BIN_W-1:0]);
   assign ram_raddr = cmd.walk_issue ? k_ff : KW'(req_bin_index);

   pjpa_ram #(
      .WIDTH (BIN_W),
      .DEPTH (NUM_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // read response
   logic rd_pend_ff, rd_oob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.accept && req_func;
      end
      rd_oob_ff <= (32'(req_bin_index) >= NUM_BINS);
   end

   assign rsp_valid             = rd_pend_ff;
   assign rsp_bin_value         = rd_oob_ff ? '0 : ram_rdata;
   assign rsp_zero_overlap_seen = zflag_ff;

`ifndef SYNTHESIS
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.accept && req_func))
      else $error("response without a read transfer");
   a_cnt_cleared: assert property (@(posedge clock) disable iff (reset)
      (mask_acc && req_last_word) |=> (cnt_ff == '0))
      else $error("overlap count not cleared at pair end");
   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(zflag_ff))
      else $error("zero-overlap flag dropped");
   a_write_after_issue: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> !cmd.clr_wr)
      else $error("bin update collides with clearing write");
`endif

endmodule
